// ===== src/sumd_pkg.sv =====
// ----------------------------------------------------------------------------
// sumd_pkg
// Shared types, constants and the byte-wise CRC-16 update for the SUMD
// frame receiver.
// ----------------------------------------------------------------------------
package sumd_pkg;

    localparam logic [7:0]  HDR_BYTE    = 8'hA8;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'h0000;
    localparam logic [15:0] CRC_TOP     = 16'h8000;
    localparam int          STORE_LIMIT = 32;

    localparam int IDX_W   = 5;          // channel index width
    localparam int TOTAL_W = 6;          // channel count width
    localparam int ADDR_W  = IDX_W + 1;  // bank bit above channel index

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_STATUS,
        PH_COUNT,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } back_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } store_wr_t;

    typedef struct packed {
        logic               bank;
        logic [7:0]         status;
        logic [TOTAL_W-1:0] total;
    } frame_cmd_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== src/sumd_front.sv =====
// ----------------------------------------------------------------------------
// sumd_front
// Byte parser: hunts for the header, checks the count, runs the CRC, writes
// channel values into the current store bank and queues good frames.
// ----------------------------------------------------------------------------
module sumd_front #(
    parameter int MAX_CHANNELS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat_valid,
    input  logic [7:0]            beat_data,
    input  logic                  q_full,
    output logic                  beat_ready,
    output sumd_pkg::store_wr_t   store_wr,
    output logic                  push,
    output sumd_pkg::frame_cmd_t  push_cmd
);

    localparam int CH_LIM = (MAX_CHANNELS < sumd_pkg::STORE_LIMIT) ?
                            MAX_CHANNELS : sumd_pkg::STORE_LIMIT;
    localparam logic [7:0] CH_LIM_B = 8'(CH_LIM);

    sumd_pkg::phase_t phase_reg, phase_next;
    logic [6:0]  pos_reg, pos_next;
    logic [5:0]  chans_reg, chans_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  status_reg, status_next;
    logic        bank_reg, bank_next;
    logic        accept;
    logic [6:0]  two_n;

    assign beat_ready = !q_full;
    assign accept     = beat_valid && beat_ready;
    assign two_n      = {chans_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sumd_pkg::PH_HEADER;
            pos_reg    <= '0;
            chans_reg  <= '0;
            crc_reg    <= sumd_pkg::CRC_INIT;
            hi_reg     <= '0;
            status_reg <= '0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            chans_reg  <= chans_next;
            crc_reg    <= crc_next;
            hi_reg     <= hi_next;
            status_reg <= status_next;
            bank_reg   <= bank_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        chans_next  = chans_reg;
        crc_next    = crc_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        bank_next   = bank_reg;
        store_wr    = '0;
        push        = 1'b0;
        push_cmd.bank   = bank_reg;
        push_cmd.status = status_reg;
        push_cmd.total  = chans_reg;
        if (accept)
        begin
            case (phase_reg)
                sumd_pkg::PH_HEADER:
                begin
                    if (beat_data == sumd_pkg::HDR_BYTE)
                    begin
                        crc_next   = sumd_pkg::crc_feed(sumd_pkg::CRC_INIT, beat_data);
                        phase_next = sumd_pkg::PH_STATUS;
                    end
                end
                sumd_pkg::PH_STATUS:
                begin
                    status_next = beat_data;
                    crc_next    = sumd_pkg::crc_feed(crc_reg, beat_data);
                    phase_next  = sumd_pkg::PH_COUNT;
                end
                sumd_pkg::PH_COUNT:
                begin
                    if (beat_data == 8'd0 || beat_data > CH_LIM_B)
                        phase_next = sumd_pkg::PH_HEADER;
                    else
                    begin
                        chans_next = beat_data[5:0];
                        crc_next   = sumd_pkg::crc_feed(crc_reg, beat_data);
                        pos_next   = '0;
                        phase_next = sumd_pkg::PH_PAYLOAD;
                    end
                end
                sumd_pkg::PH_PAYLOAD:
                begin
                    if (pos_reg < two_n)
                    begin
                        crc_next = sumd_pkg::crc_feed(crc_reg, beat_data);
                        if (!pos_reg[0])
                            hi_next = beat_data;
                        else
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.addr = {bank_reg, pos_reg[5:1]};
                            store_wr.data = {hi_reg, beat_data};
                        end
                        pos_next = pos_reg + 7'd1;
                    end
                    else if (pos_reg == two_n)
                    begin
                        hi_next  = beat_data;
                        pos_next = pos_reg + 7'd1;
                    end
                    else
                    begin
                        // frame good: hand it to the back end, switch bank
                        if ({hi_reg, beat_data} == crc_reg)
                        begin
                            push      = 1'b1;
                            bank_next = !bank_reg;
                        end
                        pos_next   = '0;
                        phase_next = sumd_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = sumd_pkg::PH_HEADER;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("frame pushed into a full queue");
    a_wr_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> (phase_reg == sumd_pkg::PH_PAYLOAD && pos_reg[0]))
        else $error("store write outside payload low byte");
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (bank_reg != $past(bank_reg)))
        else $error("bank not switched after frame push");
`endif

endmodule

// ===== src/sumd_cmdq.sv =====
// ----------------------------------------------------------------------------
// sumd_cmdq
// Two-entry queue of validated frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
module sumd_cmdq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sumd_pkg::frame_cmd_t  push_cmd,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output sumd_pkg::frame_cmd_t  head
);

    sumd_pkg::frame_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/sumd_back.sv =====
// ----------------------------------------------------------------------------
// sumd_back
// Emitter: holds the two-bank channel store and plays out one beat per
// channel of the frame at the queue head.
// ----------------------------------------------------------------------------
module sumd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sumd_pkg::store_wr_t   store_wr,
    input  logic                  q_empty,
    input  sumd_pkg::frame_cmd_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [sumd_pkg::IDX_W-1:0]   idx,
    output logic [15:0]                  value,
    output logic [7:0]                   status,
    output logic [sumd_pkg::TOTAL_W-1:0] total,
    output logic                         last
);

    localparam int DEPTH = 2 ** sumd_pkg::ADDR_W;

    logic [15:0] store_mem [DEPTH];
    logic [15:0] rdata_reg;

    sumd_pkg::back_state_t state_reg, state_next;
    logic [sumd_pkg::IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_mem[store_wr.addr] <= store_wr.data;
        rdata_reg <= store_mem[{head.bank, idx_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sumd_pkg::BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign last = ({1'b0, idx_reg} + 6'd1) == head.total;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            sumd_pkg::BK_IDLE:
            begin
                idx_next = '0;
                if (!q_empty)
                    state_next = sumd_pkg::BK_READ;
            end
            sumd_pkg::BK_READ:
            begin
                state_next = sumd_pkg::BK_SHOW;
            end
            sumd_pkg::BK_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last)
                    begin
                        pop        = 1'b1;
                        state_next = sumd_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = sumd_pkg::BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = sumd_pkg::BK_IDLE;
            end
        endcase
    end

    assign idx    = idx_reg;
    assign value  = rdata_reg;
    assign status = head.status;
    assign total  = head.total;

`ifndef SYNTHESIS
    a_valid_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_empty)
        else $error("result shown with no frame queued");
    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, idx_reg} < head.total))
        else $error("channel index beyond frame count");
    a_read_before_show: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sumd_pkg::BK_SHOW) |-> ($past(state_reg) == sumd_pkg::BK_READ
                                              || $past(state_reg) == sumd_pkg::BK_SHOW))
        else $error("result shown without a store read");
`endif

endmodule

// ===== src/sumd_frame_receiver_top.sv =====
// First beat: with the emitter idle, a good frame is pushed into the queue as its last CRC
// byte is taken, then the emitter passes BK_IDLE and BK_READ; m_tvalid rises in BK_SHOW.
// Throughput: one input byte per cycle while the frame queue has room; results leave at one
// beat per READ/SHOW pass when m_tready is high, set by the registered channel store read.
// The front stalls (s_tready low) only while two good frames wait in the queue.
// Reset: rst_n asynchronous, active low; clears parser, queue and emitter control state.
// ----------------------------------------------------------------------------
// sumd_frame_receiver_top
// SUMD frame receiver: parses serial bytes, checks CRC-16 and emits one
// beat per channel of every good frame.
// ----------------------------------------------------------------------------
module sumd_frame_receiver_top #(
    parameter int MAX_CHANNELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] channel_index, [20:5] channel_value,
                                   // [28:21] frame_status, [34:29] channel_total, zero pad
    output logic        m_tlast    // last_channel
);

    sumd_pkg::store_wr_t  store_wr;
    sumd_pkg::frame_cmd_t push_cmd;
    sumd_pkg::frame_cmd_t head;
    logic push, pop, q_full, q_empty;

    logic [sumd_pkg::IDX_W-1:0]   out_idx;
    logic [15:0]                  out_value;
    logic [7:0]                   out_status;
    logic [sumd_pkg::TOTAL_W-1:0] out_total;

    // Front end: parse bytes, run CRC, fill the store bank of the frame in flight.
    sumd_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (s_tvalid),
        .beat_data  (s_tdata),
        .q_full     (q_full),
        .beat_ready (s_tready),
        .store_wr   (store_wr),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Queue of good frames; each entry owns one store bank until fully emitted.
    sumd_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back end: read channels of the head frame and drive result beats.
    sumd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .store_wr  (store_wr),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .idx       (out_idx),
        .value     (out_value),
        .status    (out_status),
        .total     (out_total),
        .last      (m_tlast)
    );

    // Pack result fields, lowest field in the lowest bits.
    assign m_tdata = {5'b0, out_total, out_status, out_value, out_idx};

endmodule
